// ===== hdl/psmm_pkg.sv =====
// Package for the part size model matcher: field widths, result and command codes,
// register indexes, controller states and the controller/datapath interface structs.
// No dependencies.
`default_nettype none

package psmm_pkg;

   // Field widths
   localparam int DIM_W       = 12;
   localparam int AREA_W      = 24;
   localparam int DROP_W      = 8;
   localparam int SIZE_TOL_W  = 12;
   localparam int AREA_TOL_W  = 16;
   localparam int TARGET_W    = 8;
   localparam int STATUS_W    = 3;
   localparam int ID_W        = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int MODEL_W     = 2 * DIM_W + AREA_W;

   // Area test arithmetic widths
   localparam int HALF_W      = 14;
   localparam int PROD_W      = 28;
   localparam int CORR_W      = 28;
   localparam int CORR_MAG_W  = 26;
   localparam int TOLPROD_W   = AREA_TOL_W + CORR_MAG_W;
   localparam int FRAC_BITS   = 16;
   localparam int CMP_W       = CORR_W + FRAC_BITS;

   localparam logic [DROP_W-1:0] DROP_MAX = 8'hFF;

   // Register reset values
   localparam logic [SIZE_TOL_W-1:0] SIZE_TOL_RST = 12'd10;
   localparam logic [AREA_TOL_W-1:0] AREA_TOL_RST = 16'd9830;
   localparam logic                  DYN_RST      = 1'b0;
   localparam logic [TARGET_W-1:0]   TARGET_RST   = 8'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_TOL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_TOL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DYNAMIC  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET   = 2'd3;

   // Item commands
   localparam logic CMD_CLASSIFY = 1'b0;
   localparam logic CMD_COUNT    = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NEW           = 3'd0,
      STATUS_MATCHED       = 3'd1,
      STATUS_FULL          = 3'd2,
      STATUS_COUNT_TAKEN   = 3'd3,
      STATUS_COUNT_IGNORED = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_SIZE,
      ST_CORR,
      ST_TOL,
      ST_DECIDE,
      ST_STORE,
      ST_COUNT_WR,
      ST_TRAIN_INIT,
      ST_SWEEP_RD,
      ST_SWEEP_ACC,
      ST_RESP
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;          // latch item, clear walk index, step holdoff
      logic idx_clr;
      logic idx_inc;
      logic rd_model;      // read model entry at walk index
      logic rd_drop_cur;   // read drop count of current model
      logic rd_drop_idx;   // read drop count at walk index
      logic latch_size;    // register first product and model area
      logic calc_corr;
      logic calc_tol;
      logic set_match;
      logic store;
      logic count_take;
      logic count_ignore;
      logic train_clr;
      logic train_acc;
      logic train_static;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_count;
      logic dynamic;
      logic empty;
      logic idx_last;
      logic size_ok;
      logic area_ok;
      logic count_ok;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== hdl/part_size_model_matcher.sv =====
// Top level of the part size model matcher: joins controller and datapath.
// Depends on psmm_pkg, psmm_ctrl, psmm_datapath and psmm_ram.
//
// Usage:
//   An item (req_cmd, req_obj_height, req_obj_width, req_obj_area) is taken at a
//   clock edge with start high and busy low. req_cmd 0 classifies an object against
//   the model table, 1 adds a drop to the current model. Each item gives one result
//   on rsp_status, rsp_model_num and rsp_trained_models, shown for one cycle with
//   rsp_valid high; the receiver must take it then, it cannot stall.
//   Registers are written through csr_we/csr_index/csr_wdata while busy is low.
// Sequence:
//   A static classify item passes dispatch, store, trained-model init and result; a
//   taken count item has a count write in place of the store, an ignored count item
//   neither. In dynamic mode with a non-empty table, a trained-model sweep reads and
//   tests the drop count of each stored model before the result.
//   A dynamic classify reads each table entry and checks its size; an entry that passes
//   goes on to the area test (correction, tolerance, decide). The first entry is read
//   during dispatch; a match skips the store. Busy drops in the cycle after the strobe,
//   so the next item can be taken then at the earliest. The sweep and the walk each
//   read one entry per access of a table RAM with one registered read port.
// Reset:
//   Synchronous reset empties the table (fill count zero, no clearing pass), clears
//   current model and holdoff, and restores the register defaults.
`default_nettype none

module part_size_model_matcher #(
   parameter int TABLE_DEPTH   = 16,
   parameter int HOLDOFF_ITEMS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_cmd,
   input  wire logic [psmm_pkg::DIM_W-1:0]          req_obj_height,
   input  wire logic [psmm_pkg::DIM_W-1:0]          req_obj_width,
   input  wire logic [psmm_pkg::AREA_W-1:0]         req_obj_area,
   output logic                                     rsp_valid,
   output logic      [psmm_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [psmm_pkg::ID_W-1:0]           rsp_model_num,
   output logic      [psmm_pkg::ID_W-1:0]           rsp_trained_models,
   input  wire logic                                csr_we,
   input  wire logic [psmm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [psmm_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   psmm_pkg::ctl_cmd_type ctl_cmd;
   psmm_pkg::dp_sts_type  dp_sts;

   psmm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (dp_sts),
      .cmd       (ctl_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   psmm_datapath #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .HOLDOFF_ITEMS (HOLDOFF_ITEMS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (ctl_cmd),
      .sts                (dp_sts),
      .req_cmd            (req_cmd),
      .req_obj_height     (req_obj_height),
      .req_obj_width      (req_obj_width),
      .req_obj_area       (req_obj_area),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_status         (rsp_status),
      .rsp_model_num      (rsp_model_num),
      .rsp_trained_models (rsp_trained_models)
   );

   // A result only appears while an item is in work
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside an item");

   // An accepted item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not start work");

   // One strobe per item, then back to idle
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe longer than one cycle");

   // Model number never names an entry beyond the table
   a_id_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (TABLE_DEPTH < 32)) |-> (32'(rsp_model_num) <= TABLE_DEPTH))
      else $error("model number beyond table depth");

endmodule

`default_nettype wire

// ===== hdl/psmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module psmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                          clock,
   input  wire logic                                          wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  wire logic [WIDTH-1:0]                              wr_data,
   input  wire logic                                          rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic      [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/psmm_ctrl.sv =====
// Controller for the part size model matcher: sequences the table walk, the store,
// the count update and the trained-model sweep. Depends on psmm_pkg.
`default_nettype none

module psmm_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire psmm_pkg::dp_sts_type  sts,
   output psmm_pkg::ctl_cmd_type      cmd,
   output logic                       busy,
   output logic                       rsp_valid
);

   psmm_pkg::state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psmm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         psmm_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = psmm_pkg::ST_DISPATCH;
            end
         end
         psmm_pkg::ST_DISPATCH: begin
            if (sts.is_count) begin
               if (sts.count_ok) begin
                  cmd.rd_drop_cur = 1'b1;
                  state_in        = psmm_pkg::ST_COUNT_WR;
               end else begin
                  cmd.count_ignore = 1'b1;
                  state_in         = psmm_pkg::ST_TRAIN_INIT;
               end
            end else if (sts.dynamic && !sts.empty) begin
               // walk index is zero after load
               cmd.rd_model = 1'b1;
               state_in     = psmm_pkg::ST_SIZE;
            end else begin
               state_in = psmm_pkg::ST_STORE;
            end
         end
         psmm_pkg::ST_READ: begin
            cmd.rd_model = 1'b1;
            state_in     = psmm_pkg::ST_SIZE;
         end
         psmm_pkg::ST_SIZE: begin
            cmd.latch_size = 1'b1;
            if (sts.size_ok) begin
               state_in = psmm_pkg::ST_CORR;
            end else if (sts.idx_last) begin
               state_in = psmm_pkg::ST_STORE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = psmm_pkg::ST_READ;
            end
         end
         psmm_pkg::ST_CORR: begin
            cmd.calc_corr = 1'b1;
            state_in      = psmm_pkg::ST_TOL;
         end
         psmm_pkg::ST_TOL: begin
            cmd.calc_tol = 1'b1;
            state_in     = psmm_pkg::ST_DECIDE;
         end
         psmm_pkg::ST_DECIDE: begin
            if (sts.area_ok) begin
               cmd.set_match = 1'b1;
               state_in      = psmm_pkg::ST_TRAIN_INIT;
            end else if (sts.idx_last) begin
               state_in = psmm_pkg::ST_STORE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = psmm_pkg::ST_READ;
            end
         end
         psmm_pkg::ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = psmm_pkg::ST_TRAIN_INIT;
         end
         psmm_pkg::ST_COUNT_WR: begin
            cmd.count_take = 1'b1;
            state_in       = psmm_pkg::ST_TRAIN_INIT;
         end
         psmm_pkg::ST_TRAIN_INIT: begin
            // static mode or empty table: every stored model counts
            if (!sts.dynamic || sts.empty) begin
               cmd.train_static = 1'b1;
               state_in         = psmm_pkg::ST_RESP;
            end else begin
               cmd.train_clr = 1'b1;
               cmd.idx_clr   = 1'b1;
               state_in      = psmm_pkg::ST_SWEEP_RD;
            end
         end
         psmm_pkg::ST_SWEEP_RD: begin
            cmd.rd_drop_idx = 1'b1;
            state_in        = psmm_pkg::ST_SWEEP_ACC;
         end
         psmm_pkg::ST_SWEEP_ACC: begin
            cmd.train_acc = 1'b1;
            if (sts.idx_last) begin
               state_in = psmm_pkg::ST_RESP;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = psmm_pkg::ST_SWEEP_RD;
            end
         end
         psmm_pkg::ST_RESP: begin
            state_in = psmm_pkg::ST_IDLE;
         end
         default: begin
            state_in = psmm_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != psmm_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == psmm_pkg::ST_RESP);

endmodule

`default_nettype wire

// ===== hdl/psmm_datapath.sv =====
// Datapath for the part size model matcher: configuration registers, item registers,
// model and drop count tables, area test arithmetic and result registers.
// Depends on psmm_pkg and psmm_ram.
`default_nettype none

module psmm_datapath #(
   parameter int TABLE_DEPTH   = 16,
   parameter int HOLDOFF_ITEMS = 4
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire psmm_pkg::ctl_cmd_type               cmd,
   output psmm_pkg::dp_sts_type                     sts,
   input  wire logic                                req_cmd,
   input  wire logic [psmm_pkg::DIM_W-1:0]          req_obj_height,
   input  wire logic [psmm_pkg::DIM_W-1:0]          req_obj_width,
   input  wire logic [psmm_pkg::AREA_W-1:0]         req_obj_area,
   input  wire logic                                csr_we,
   input  wire logic [psmm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [psmm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic      [psmm_pkg::STATUS_W-1:0]       rsp_status,
   output logic      [psmm_pkg::ID_W-1:0]           rsp_model_num,
   output logic      [psmm_pkg::ID_W-1:0]           rsp_trained_models
);

   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int HOLD_W = $clog2(HOLDOFF_ITEMS + 1);

   // Configuration
   logic [psmm_pkg::SIZE_TOL_W-1:0] size_tol_ff;
   logic [psmm_pkg::AREA_TOL_W-1:0] area_tol_ff;
   logic                            dyn_ff;
   logic [psmm_pkg::TARGET_W-1:0]   target_ff;

   // Item
   logic                            cmd_ff;
   logic [psmm_pkg::DIM_W-1:0]      obj_h_ff;
   logic [psmm_pkg::DIM_W-1:0]      obj_w_ff;
   logic [psmm_pkg::AREA_W-1:0]     obj_a_ff;

   // Control state
   logic [IDX_W-1:0]                idx_ff;
   logic [CNT_W-1:0]                used_ff;
   logic [CNT_W-1:0]                cur_ff;
   logic [HOLD_W-1:0]               hold_ff;
   logic [CNT_W-1:0]                trained_ff;
   psmm_pkg::status_type            status_ff;

   // Area test pipeline
   logic signed [psmm_pkg::PROD_W-1:0]  p1_ff, p1_in;
   logic signed [psmm_pkg::HALF_W-1:0]  dw2_ff;
   logic [psmm_pkg::AREA_W-1:0]         marea_ff;
   logic signed [psmm_pkg::CORR_W-1:0]  corr_ff, corr_in;
   logic [psmm_pkg::CORR_W-1:0]         err_ff, err_in;
   logic [psmm_pkg::TOLPROD_W-1:0]      tolprod_ff, tolprod_in;
   logic                                corr_pos_ff;

   // Table ports
   logic [psmm_pkg::MODEL_W-1:0]    model_rd;
   logic [psmm_pkg::DROP_W-1:0]     drop_rd;
   logic                            model_we;
   logic                            drop_we, drop_re;
   logic [IDX_W-1:0]                drop_wr_addr, drop_rd_addr;
   logic [psmm_pkg::DROP_W-1:0]     drop_wr_data;

   logic [psmm_pkg::DIM_W-1:0]      m_h, m_w;
   logic [psmm_pkg::AREA_W-1:0]     m_a;
   logic [CNT_W-1:0]                cur_m1;
   logic [IDX_W-1:0]                cur_idx, used_idx;
   logic                            full;

   logic signed [psmm_pkg::DIM_W:0] h_diff, w_diff;
   logic [psmm_pkg::DIM_W:0]        h_abs, w_abs;
   logic signed [psmm_pkg::HALF_W-1:0] dh, dw, dh_rnd, dw_rnd, dh2, dw2;
   logic signed [psmm_pkg::HALF_W-1:0] h_s, w_s;
   logic signed [psmm_pkg::CORR_W-1:0] a_s, area_diff;
   logic [31:0]                     cur_wide, trained_wide;

   assign m_h = model_rd[psmm_pkg::MODEL_W-1 -: psmm_pkg::DIM_W];
   assign m_w = model_rd[psmm_pkg::AREA_W +: psmm_pkg::DIM_W];
   assign m_a = model_rd[psmm_pkg::AREA_W-1:0];

   assign cur_m1   = cur_ff - CNT_W'(1);
   assign cur_idx  = cur_m1[IDX_W-1:0];
   assign used_idx = used_ff[IDX_W-1:0];
   assign full     = (used_ff == CNT_W'(TABLE_DEPTH));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         size_tol_ff <= psmm_pkg::SIZE_TOL_RST;
         area_tol_ff <= psmm_pkg::AREA_TOL_RST;
         dyn_ff      <= psmm_pkg::DYN_RST;
         target_ff   <= psmm_pkg::TARGET_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            psmm_pkg::CSR_SIZE_TOL: size_tol_ff <= csr_wdata[psmm_pkg::SIZE_TOL_W-1:0];
            psmm_pkg::CSR_AREA_TOL: area_tol_ff <= csr_wdata[psmm_pkg::AREA_TOL_W-1:0];
            psmm_pkg::CSR_DYNAMIC:  dyn_ff      <= csr_wdata[0];
            psmm_pkg::CSR_TARGET:   target_ff   <= csr_wdata[psmm_pkg::TARGET_W-1:0];
            default: ;
         endcase
      end
   end

   // Size differences against the entry just read
   assign h_diff = $signed({1'b0, obj_h_ff}) - $signed({1'b0, m_h});
   assign w_diff = $signed({1'b0, obj_w_ff}) - $signed({1'b0, m_w});
   assign h_abs  = h_diff[psmm_pkg::DIM_W] ? unsigned'(-h_diff) : unsigned'(h_diff);
   assign w_abs  = w_diff[psmm_pkg::DIM_W] ? unsigned'(-w_diff) : unsigned'(w_diff);

   // Halved differences, truncated toward zero
   assign dh     = $signed({2'b0, m_h}) - $signed({2'b0, obj_h_ff})
                   - psmm_pkg::HALF_W'(1);
   assign dw     = $signed({2'b0, m_w}) - $signed({2'b0, obj_w_ff})
                   - psmm_pkg::HALF_W'(1);
   assign dh_rnd = dh + $signed({{(psmm_pkg::HALF_W-1){1'b0}}, dh[psmm_pkg::HALF_W-1]});
   assign dw_rnd = dw + $signed({{(psmm_pkg::HALF_W-1){1'b0}}, dw[psmm_pkg::HALF_W-1]});
   assign dh2    = dh_rnd >>> 1;
   assign dw2    = dw_rnd >>> 1;

   assign h_s = $signed({2'b0, obj_h_ff});
   assign w_s = $signed({2'b0, obj_w_ff});
   assign a_s = $signed({{(psmm_pkg::CORR_W-psmm_pkg::AREA_W){1'b0}}, obj_a_ff});

   // One multiply per stage
   assign p1_in      = dh2 * w_s;
   assign corr_in    = a_s + p1_ff + dw2_ff * h_s;
   assign area_diff  = corr_ff
                       - $signed({{(psmm_pkg::CORR_W-psmm_pkg::AREA_W){1'b0}}, marea_ff});
   assign err_in     = area_diff[psmm_pkg::CORR_W-1] ? unsigned'(-area_diff)
                                                    : unsigned'(area_diff);
   assign tolprod_in = area_tol_ff * corr_ff[psmm_pkg::CORR_MAG_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.latch_size) begin
         p1_ff    <= p1_in;
         dw2_ff   <= dw2;
         marea_ff <= m_a;
      end
      if (cmd.calc_corr) begin
         corr_ff <= corr_in;
      end
      if (cmd.calc_tol) begin
         err_ff      <= err_in;
         tolprod_ff  <= tolprod_in;
         corr_pos_ff <= !corr_ff[psmm_pkg::CORR_W-1] && (corr_ff != '0);
      end
   end

   // Item registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_cmd;
         obj_h_ff <= req_obj_height;
         obj_w_ff <= req_obj_width;
         obj_a_ff <= req_obj_area;
      end
   end

   // Walk index, table fill, current model, holdoff
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         used_ff <= '0;
         cur_ff  <= '0;
         hold_ff <= '0;
      end else begin
         if (cmd.load || cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         // classify items step the holdoff down
         if (cmd.load && (req_cmd == psmm_pkg::CMD_CLASSIFY) && (hold_ff != '0)) begin
            hold_ff <= hold_ff - HOLD_W'(1);
         end else if (cmd.count_take) begin
            hold_ff <= HOLD_W'(HOLDOFF_ITEMS);
         end
         if (cmd.set_match) begin
            cur_ff <= CNT_W'(idx_ff) + CNT_W'(1);
         end else if (cmd.store) begin
            if (full) begin
               cur_ff <= '0;
            end else begin
               cur_ff  <= used_ff + CNT_W'(1);
               used_ff <= used_ff + CNT_W'(1);
            end
         end
      end
   end

   // Result status and trained count
   always_ff @(posedge clock) begin
      if (cmd.set_match) begin
         status_ff <= psmm_pkg::STATUS_MATCHED;
      end else if (cmd.store) begin
         if (full) begin
            status_ff <= psmm_pkg::STATUS_FULL;
         end else begin
            status_ff <= psmm_pkg::STATUS_NEW;
         end
      end else if (cmd.count_take) begin
         status_ff <= psmm_pkg::STATUS_COUNT_TAKEN;
      end else if (cmd.count_ignore) begin
         status_ff <= psmm_pkg::STATUS_COUNT_IGNORED;
      end
      if (cmd.train_static) begin
         trained_ff <= used_ff;
      end else if (cmd.train_clr) begin
         trained_ff <= '0;
      end else if (cmd.train_acc && (drop_rd >= target_ff)) begin
         trained_ff <= trained_ff + CNT_W'(1);
      end
   end

   // Table write and read control
   assign model_we     = cmd.store && !full;
   assign drop_we      = model_we || cmd.count_take;
   assign drop_wr_addr = cmd.count_take ? cur_idx : used_idx;
   assign drop_wr_data = cmd.count_take
                         ? ((drop_rd == psmm_pkg::DROP_MAX) ? drop_rd
                                                            : drop_rd + psmm_pkg::DROP_W'(1))
                         : '0;
   assign drop_re      = cmd.rd_drop_cur || cmd.rd_drop_idx;
   assign drop_rd_addr = cmd.rd_drop_cur ? cur_idx : idx_ff;

   psmm_ram #(
      .WIDTH (psmm_pkg::MODEL_W),
      .DEPTH (TABLE_DEPTH)
   ) u_model_ram (
      .clock   (clock),
      .wr_en   (model_we),
      .wr_addr (used_idx),
      .wr_data ({obj_h_ff, obj_w_ff, obj_a_ff}),
      .rd_en   (cmd.rd_model),
      .rd_addr (idx_ff),
      .rd_data (model_rd)
   );

   psmm_ram #(
      .WIDTH (psmm_pkg::DROP_W),
      .DEPTH (TABLE_DEPTH)
   ) u_drop_ram (
      .clock   (clock),
      .wr_en   (drop_we),
      .wr_addr (drop_wr_addr),
      .wr_data (drop_wr_data),
      .rd_en   (drop_re),
      .rd_addr (drop_rd_addr),
      .rd_data (drop_rd)
   );

   // Status to controller
   assign sts.is_count = (cmd_ff == psmm_pkg::CMD_COUNT);
   assign sts.dynamic  = dyn_ff;
   assign sts.empty    = (used_ff == '0);
   assign sts.idx_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == used_ff);
   assign sts.size_ok  = (h_abs < {1'b0, size_tol_ff}) && (w_abs < {1'b0, size_tol_ff});
   assign sts.area_ok  = corr_pos_ff
                         && ({err_ff, {psmm_pkg::FRAC_BITS{1'b0}}}
                             < psmm_pkg::CMP_W'(tolprod_ff));
   assign sts.count_ok = (hold_ff == '0) && (cur_ff != '0) && (cur_ff <= used_ff);

   // Results, ids masked to the port width
   assign cur_wide           = 32'(cur_ff);
   assign trained_wide       = 32'(trained_ff);
   assign rsp_status         = status_ff;
   assign rsp_model_num      = cur_wide[psmm_pkg::ID_W-1:0];
   assign rsp_trained_models = trained_wide[psmm_pkg::ID_W-1:0];

endmodule

`default_nettype wire
